FILE: hw/rtl/assert_macros.svh
// Assertion helper macros used by bpba_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bpba_pkg.sv
// ----------------------------------------------------------------------------
// bpba_pkg
// Shared types and constants of the block page bitmap allocator.
// ----------------------------------------------------------------------------
package bpba_pkg;

    localparam int NUM_BLOCKS_DEF      = 16;
    localparam int PAGES_PER_BLOCK_DEF = 64;
    localparam int PAGE_SHIFT_DEF      = 12;
    localparam int MAX_PER_REQ_DEF     = 64;

    localparam int ADDR_W  = 22;
    localparam int AMT_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int MAX_RESULTS = 64;

    localparam logic [FUNC_W-1:0] FN_MAP   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ILLEGAL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd3;

    // Classified command handed from front end to back end.
    typedef enum logic [2:0] {
        CMD_MAP   = 3'd0,
        CMD_ALLOC = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_ERR   = 3'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [AMT_W-1:0] amount;
        logic [7:0]       blk;
        logic [5:0]       pg;
    } job_t;

endpackage

FILE: hw/rtl/bpba_front.sv
// ----------------------------------------------------------------------------
// bpba_front
// Accepts request words, classifies them and pushes jobs into a small queue.
// ----------------------------------------------------------------------------
module bpba_front #(
    parameter int NUM_BLOCKS      = bpba_pkg::NUM_BLOCKS_DEF,
    parameter int PAGES_PER_BLOCK = bpba_pkg::PAGES_PER_BLOCK_DEF,
    parameter int PAGE_SHIFT_BITS = bpba_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_PER_REQUEST = bpba_pkg::MAX_PER_REQ_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bpba_pkg::FUNC_W-1:0] func,
    input  logic [bpba_pkg::AMT_W-1:0]  amount_requested,
    input  logic [bpba_pkg::ADDR_W-1:0] page_addr,
    output logic                        job_valid,
    input  logic                        job_ready,
    output bpba_pkg::job_t              job
);
    import bpba_pkg::*;

    localparam int PBITS  = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
    localparam int BSHIFT = PAGE_SHIFT_BITS + PBITS;
    localparam int DEPTH  = 2;

    job_t       q_reg [DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       cls;
    logic [ADDR_W-1:0] blk_full, pg_full;
    logic       push, pop;

    // Classify request
    always_comb
    begin
        blk_full = page_addr >> BSHIFT;
        pg_full  = (page_addr >> PAGE_SHIFT_BITS) & ((ADDR_W'(1) << PBITS) - ADDR_W'(1));
        cls.amount = amount_requested;
        cls.blk    = blk_full[7:0];
        cls.pg     = pg_full[5:0];
        case (func)
            FN_MAP:   cls.cmd = CMD_MAP;
            FN_ALLOC: cls.cmd = (amount_requested > AMT_W'(MAX_PER_REQUEST)) ?
                                CMD_ERR : CMD_ALLOC;
            FN_FREE:  cls.cmd = (blk_full >= ADDR_W'(NUM_BLOCKS) ||
                                 pg_full >= ADDR_W'(PAGES_PER_BLOCK)) ? CMD_ERR : CMD_FREE;
            default:  cls.cmd = CMD_ERR;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'(DEPTH));
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];

    // Queue pointers
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

endmodule

FILE: hw/rtl/bpba_back.sv
// ----------------------------------------------------------------------------
// bpba_back
// Carries out jobs against block flags, page bitmaps and use counts; emits
// result words through an output register.
// ----------------------------------------------------------------------------
module bpba_back #(
    parameter int NUM_BLOCKS      = bpba_pkg::NUM_BLOCKS_DEF,
    parameter int PAGES_PER_BLOCK = bpba_pkg::PAGES_PER_BLOCK_DEF,
    parameter int PAGE_SHIFT_BITS = bpba_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  bpba_pkg::job_t              job,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bpba_pkg::ADDR_W-1:0] page_addr_out,
    output logic [bpba_pkg::STAT_W-1:0] status,
    output logic [bpba_pkg::AMT_W-1:0]  amount_done,
    output logic                        last
);
    import bpba_pkg::*;

    localparam int PBITS  = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
    localparam int BSHIFT = PAGE_SHIFT_BITS + PBITS;
    localparam int BW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BCW    = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PAGE = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [NUM_BLOCKS-1:0]     in_use_reg, in_use_next;
    logic [PAGES_PER_BLOCK-1:0] map_reg [NUM_BLOCKS];
    logic [AMT_W-1:0]          used_reg [NUM_BLOCKS];
    job_t                      job_reg, job_next;
    logic [BCW-1:0]            blk_reg, blk_next;
    logic [AMT_W-1:0]          cnt_reg, cnt_next;
    logic [PAGES_PER_BLOCK-1:0] cur_map;
    logic [PBITS-1:0]          free_pg;
    logic                      any_free;
    logic                      ov_reg, ov_next;
    logic [ADDR_W-1:0]         oa_reg, oa_next;
    logic [STAT_W-1:0]         os_reg, os_next;
    logic [AMT_W-1:0]          od_reg, od_next;
    logic                      ol_reg, ol_next;
    logic                      map_we, used_we, set_bit;
    logic [BW-1:0]             we_blk;
    logic [PBITS-1:0]          we_pg;
    logic [AMT_W-1:0]          used_wdata;
    logic                      out_free;
    logic [BW-1:0]             bi;

    assign out_free  = !ov_reg || out_ready;
    assign job_ready = (state_reg == S_IDLE) && out_free;
    assign bi        = blk_reg[BW-1:0];
    assign cur_map   = map_reg[bi];

    // Lowest clear page of the current block (priority encoder)
    always_comb
    begin
        free_pg  = '0;
        any_free = 1'b0;
        for (int p = PAGES_PER_BLOCK - 1; p >= 0; p--)
        begin
            if (!cur_map[p])
            begin
                free_pg  = PBITS'(p);
                any_free = 1'b1;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        in_use_next = in_use_reg;
        job_next    = job_reg;
        blk_next    = blk_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && !out_ready;
        oa_next     = oa_reg;
        os_next     = os_reg;
        od_next     = od_reg;
        ol_next     = ol_reg;
        map_we      = 1'b0;
        used_we     = 1'b0;
        set_bit     = 1'b0;
        we_blk      = job_reg.blk[BW-1:0];
        we_pg       = job_reg.pg[PBITS-1:0];
        used_wdata  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    job_next = job;
                    blk_next = '0;
                    cnt_next = '0;
                    case (job.cmd)
                        CMD_MAP:   state_next = S_SCAN;
                        CMD_ALLOC: state_next = (job.amount == '0) ? S_EMIT : S_SCAN;
                        CMD_FREE:  state_next = S_PAGE;
                        default:
                        begin
                            ov_next = 1'b1; oa_next = '0; os_next = ST_ILLEGAL;
                            od_next = '0;   ol_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (blk_reg >= BCW'(NUM_BLOCKS) || cnt_reg >= job_reg.amount)
                    state_next = S_EMIT;
                else if (job_reg.cmd == CMD_MAP)
                begin
                    if (!in_use_reg[bi])
                    begin
                        in_use_next[bi] = 1'b1;
                        cnt_next = cnt_reg + AMT_W'(1);
                    end
                    blk_next = blk_reg + BCW'(1);
                end
                else if (!in_use_reg[bi] || !any_free)
                    blk_next = blk_reg + BCW'(1);
                else if (out_free)
                begin
                    // Grant one page; the final grant is marked when the scan ends
                    map_we  = 1'b1;
                    set_bit = 1'b1;
                    we_blk  = bi;
                    we_pg   = free_pg;
                    used_we = 1'b1;
                    used_wdata = used_reg[bi] + AMT_W'(1);
                    cnt_next = cnt_reg + AMT_W'(1);
                    ov_next = 1'b1;
                    oa_next = ADDR_W'((ADDR_W'(bi) << BSHIFT) |
                                      (ADDR_W'(free_pg) << PAGE_SHIFT_BITS));
                    os_next = ST_OK;
                    od_next = cnt_reg + AMT_W'(1);
                    ol_next = 1'b0;
                    // Hold last grant back until we know it is last: emit only
                    // when the register is free, patch last in S_EMIT instead
                    state_next = S_SCAN;
                end
            end
            S_PAGE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; oa_next = '0; ol_next = 1'b1;
                    if (map_reg[we_blk][we_pg])
                    begin
                        map_we = 1'b1;
                        used_we = 1'b1;
                        used_wdata = used_reg[we_blk] - AMT_W'(1);
                        os_next = ST_OK; od_next = AMT_W'(1);
                    end
                    else
                    begin
                        os_next = ST_NOT_ALLOC; od_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (job_reg.cmd == CMD_MAP)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; oa_next = '0; os_next = ST_OK;
                        od_next = cnt_reg; ol_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; oa_next = '0; os_next = ST_NONE;
                        od_next = '0; ol_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    // last grant still held in the staging slot
                    ol_next = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic pend_reg, pend_next;
    logic [ADDR_W-1:0] pa_reg;
    logic [AMT_W-1:0]  pd_reg;

    // Pending grant staging: grants go to a staging slot first, move out when
    // the next grant arrives or when the scan finishes.
    always_comb
    begin
        pend_next = pend_reg;
        if (set_bit) pend_next = 1'b1;
        else if (state_reg == S_EMIT && job_reg.cmd == CMD_ALLOC && out_free)
            pend_next = 1'b0;
    end

    logic              fv;
    logic [ADDR_W-1:0] fa;
    logic [STAT_W-1:0] fs;
    logic [AMT_W-1:0]  fd;
    logic              fl;
    always_comb
    begin
        fv = ov_next; fa = oa_next; fs = os_next; fd = od_next; fl = ol_next;
        if (job_reg.cmd == CMD_ALLOC && (state_reg == S_SCAN || state_reg == S_EMIT))
        begin
            fv = ov_reg && !out_ready; fa = oa_reg; fs = os_reg; fd = od_reg;
            fl = ol_reg;
            if (set_bit && pend_reg)
            begin
                fv = 1'b1; fa = pa_reg; fs = ST_OK; fd = pd_reg; fl = 1'b0;
            end
            else if (state_reg == S_EMIT && out_free)
            begin
                fv = 1'b1; fl = 1'b1; fa = pend_reg ? pa_reg : '0;
                fs = pend_reg ? ST_OK : ST_NONE; fd = pend_reg ? pd_reg : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
            ov_reg     <= 1'b0;
            pend_reg   <= 1'b0;
            blk_reg    <= '0;
            cnt_reg    <= '0;
            for (int b = 0; b < NUM_BLOCKS; b++)
            begin
                map_reg[b]  <= '0;
                used_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            ov_reg     <= fv;
            pend_reg   <= (state_reg == S_IDLE) ? 1'b0 : pend_next;
            blk_reg    <= blk_next;
            cnt_reg    <= cnt_next;
            if (map_we)
                map_reg[we_blk][we_pg] <= set_bit;
            if (used_we)
                used_reg[we_blk] <= used_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        oa_reg  <= fa;
        os_reg  <= fs;
        od_reg  <= fd;
        ol_reg  <= fl;
        if (set_bit)
        begin
            pa_reg <= oa_next;
            pd_reg <= od_next;
        end
    end

    assign out_valid     = ov_reg;
    assign page_addr_out = oa_reg;
    assign status        = os_reg;
    assign amount_done   = od_reg;
    assign last          = ol_reg;

endmodule

FILE: hw/rtl/block_page_bitmap_allocator_top.sv
// Block page bitmap allocator. Requests enter a two-word queue and are run
// one at a time by a sequencer that walks the blocks, one block per cycle;
// an alloc stays on a block while it grants its pages, waiting while the
// output is stalled. Reset clears the control state, block flags, page
// bitmaps and use counts, not the queue entries or output data registers.
// ----------------------------------------------------------------------------
// block_page_bitmap_allocator_top
// Top level: front-end classifier and queue, back-end allocation sequencer.
// ----------------------------------------------------------------------------
module block_page_bitmap_allocator_top #(
    parameter int NUM_BLOCKS      = bpba_pkg::NUM_BLOCKS_DEF,
    parameter int PAGES_PER_BLOCK = bpba_pkg::PAGES_PER_BLOCK_DEF,
    parameter int PAGE_SHIFT_BITS = bpba_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_PER_REQUEST = bpba_pkg::MAX_PER_REQ_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bpba_pkg::FUNC_W-1:0] func,
    input  logic [bpba_pkg::AMT_W-1:0]  amount_requested,
    input  logic [bpba_pkg::ADDR_W-1:0] page_addr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bpba_pkg::ADDR_W-1:0] page_addr_out,
    output logic [bpba_pkg::STAT_W-1:0] status,
    output logic [bpba_pkg::AMT_W-1:0]  amount_done,
    output logic                        last
);
    import bpba_pkg::*;

    job_t job;
    logic job_valid, job_ready;

    bpba_front #(
        .NUM_BLOCKS(NUM_BLOCKS), .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
        .PAGE_SHIFT_BITS(PAGE_SHIFT_BITS), .MAX_PER_REQUEST(MAX_PER_REQUEST)
    ) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .func, .amount_requested, .page_addr,
        .job_valid, .job_ready, .job
    );

    bpba_back #(
        .NUM_BLOCKS(NUM_BLOCKS), .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
        .PAGE_SHIFT_BITS(PAGE_SHIFT_BITS)
    ) u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .out_valid, .out_ready, .page_addr_out, .status, .amount_done, .last
    );

endmodule

FILE: hw/rtl/bpba_checker.sv
// ----------------------------------------------------------------------------
// bpba_checker
// Port-level checks of the allocator's result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpba_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bpba_pkg::ADDR_W-1:0] page_addr_out,
    input logic [bpba_pkg::STAT_W-1:0] status,
    input logic [bpba_pkg::AMT_W-1:0]  amount_done,
    input logic                        last
);
    import bpba_pkg::*;

    `CHK_IMPL(a_err_last, clk, rst_n, out_valid && status != ST_OK, last, "error word not last")
    `CHK_IMPL(a_err_zero, clk, rst_n, out_valid && status != ST_OK, amount_done == '0 && page_addr_out == '0, "error word carries data")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(page_addr_out) && $stable(last), "stalled word changed")
    `CHK_NEXT(a_seq, clk, rst_n, out_valid && out_ready && !last, !out_valid || amount_done == $past(amount_done) + 7'd1, "grant count skipped")

endmodule

bind block_page_bitmap_allocator_top bpba_checker u_chk (
    .clk, .rst_n, .out_valid, .out_ready, .page_addr_out, .status, .amount_done, .last
);

FILE: verif/block_page_bitmap_allocator_checker.sv
// ----------------------------------------------------------------------------
// block_page_bitmap_allocator_checker
// Watches both channels of the page allocator. It keeps its own copy of the
// block flags, page bitmaps and used-page counts, works out the result words
// of every accepted request and compares each returned word with the oldest
// one still expected.
// ----------------------------------------------------------------------------
module block_page_bitmap_allocator_checker
    import bpba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [AMT_W-1:0]  amount_requested,
    input  logic [ADDR_W-1:0] page_addr,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [ADDR_W-1:0] page_addr_out,
    input  logic [STAT_W-1:0] status,
    input  logic [AMT_W-1:0]  amount_done,
    input  logic              last,
    output int                errors,
    output int                pending
);

    localparam int NBLK      = NUM_BLOCKS_DEF;
    localparam int NPG       = PAGES_PER_BLOCK_DEF;
    localparam int PG_SHIFT  = PAGE_SHIFT_DEF;
    localparam int PG_BITS   = $clog2(NPG);
    localparam int BLK_SHIFT = PG_SHIFT + PG_BITS;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] st;
        logic [AMT_W-1:0]  done;
        logic              fin;
    } result_word_t;

    // Shadow allocator state
    logic             blk_mapped [NBLK];
    logic [NPG-1:0]   blk_bitmap [NBLK];
    logic [AMT_W-1:0] blk_used   [NBLK];

    result_word_t expected_words[$];

    function automatic result_word_t single_word(logic [STAT_W-1:0] st,
                                                 logic [AMT_W-1:0] done);
        result_word_t w;
        w.addr = '0;
        w.st   = st;
        w.done = done;
        w.fin  = 1'b1;
        return w;
    endfunction

    // Apply one request to the shadow state and queue its result words
    task automatic predict_request(logic [FUNC_W-1:0] fn, logic [AMT_W-1:0] amt,
                                   logic [ADDR_W-1:0] addr);
        int           cnt;
        int           blk;
        int           pg;
        result_word_t grants[$];
        result_word_t w;
        cnt = 0;
        case (fn)
            FN_MAP:
            begin
                for (int b = 0; b < NBLK && cnt < amt; b++)
                    if (!blk_mapped[b])
                    begin
                        blk_mapped[b] = 1'b1;
                        cnt++;
                    end
                expected_words.push_back(single_word(ST_OK, AMT_W'(cnt)));
            end
            FN_ALLOC:
            begin
                if (amt > MAX_PER_REQ_DEF)
                    expected_words.push_back(single_word(ST_ILLEGAL, '0));
                else
                begin
                    for (int b = 0; b < NBLK && cnt < amt; b++)
                    begin
                        if (!blk_mapped[b] || blk_used[b] >= NPG)
                            continue;
                        for (int p = 0; p < NPG && cnt < amt; p++)
                            if (!blk_bitmap[b][p])
                            begin
                                blk_bitmap[b][p] = 1'b1;
                                blk_used[b]      = blk_used[b] + 1'b1;
                                cnt++;
                                w.addr = ADDR_W'((b << BLK_SHIFT) | (p << PG_SHIFT));
                                w.st   = ST_OK;
                                w.done = AMT_W'(cnt);
                                w.fin  = 1'b0;
                                grants.push_back(w);
                            end
                    end
                    if (cnt == 0)
                        expected_words.push_back(single_word(ST_NONE, '0));
                    else
                    begin
                        grants[grants.size()-1].fin = 1'b1;
                        foreach (grants[i])
                            expected_words.push_back(grants[i]);
                    end
                end
            end
            FN_FREE:
            begin
                blk = int'(addr >> BLK_SHIFT);
                pg  = int'((addr >> PG_SHIFT) & ((1 << PG_BITS) - 1));
                if (blk >= NBLK || pg >= NPG)
                    expected_words.push_back(single_word(ST_ILLEGAL, '0));
                else if (blk_bitmap[blk][pg])
                begin
                    blk_bitmap[blk][pg] = 1'b0;
                    blk_used[blk]       = blk_used[blk] - 1'b1;
                    expected_words.push_back(single_word(ST_OK, AMT_W'(1)));
                end
                else
                    expected_words.push_back(single_word(ST_NOT_ALLOC, '0));
            end
            default:
                expected_words.push_back(single_word(ST_ILLEGAL, '0));
        endcase
    endtask

    // Sample both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t exp_w;
        if (!rst_n)
        begin
            for (int b = 0; b < NBLK; b++)
            begin
                blk_mapped[b] = 1'b0;
                blk_bitmap[b] = '0;
                blk_used[b]   = '0;
            end
            expected_words.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: addr %0h status %0d done %0d last %0d",
                           page_addr_out, status, amount_done, last);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (page_addr_out !== exp_w.addr)
                    begin
                        $error("page_addr_out: expected %0h, got %0h", exp_w.addr, page_addr_out);
                        errors++;
                    end
                    if (status !== exp_w.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.st, status);
                        errors++;
                    end
                    if (amount_done !== exp_w.done)
                    begin
                        $error("amount_done: expected %0d, got %0d", exp_w.done, amount_done);
                        errors++;
                    end
                    if (last !== exp_w.fin)
                    begin
                        $error("last: expected %0d, got %0d", exp_w.fin, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_request(func, amount_requested, page_addr);
        end
        pending = expected_words.size();
    end

endmodule

FILE: verif/tb_block_page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_block_page_bitmap_allocator_top
// Drives map, alloc, free and illegal words into the allocator with random
// gaps and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_block_page_bitmap_allocator_top;
    import bpba_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNKNOWN = 2'd3;
    localparam int RANDOM_WORDS = 280;
    localparam int DRAIN_CYCLES = 200;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [FUNC_W-1:0] func;
    logic [AMT_W-1:0]  amount_requested;
    logic [ADDR_W-1:0] page_addr;
    logic              out_valid;
    logic              out_ready;
    logic [ADDR_W-1:0] page_addr_out;
    logic [STAT_W-1:0] status;
    logic [AMT_W-1:0]  amount_done;
    logic              last;
    int                errors;
    int                pending;

    block_page_bitmap_allocator_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .amount_requested (amount_requested),
        .page_addr        (page_addr),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .page_addr_out    (page_addr_out),
        .status           (status),
        .amount_done      (amount_done),
        .last             (last)
    );

    block_page_bitmap_allocator_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .amount_requested (amount_requested),
        .page_addr        (page_addr),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .page_addr_out    (page_addr_out),
        .status           (status),
        .amount_done      (amount_done),
        .last             (last),
        .errors           (errors),
        .pending          (pending)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random stalls on the result side, with stall-free stretches
    always @(posedge clk)
    begin
        int stall;
        if (stall > 0)
        begin
            stall--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall = gap_len();
            out_ready <= (stall == 0);
        end
        else
            out_ready <= 1'b1;
    end

    // Present one word and hold it until accepted, then sometimes idle for a random gap
    task automatic send_word(logic [FUNC_W-1:0] fn, logic [AMT_W-1:0] amt,
                             logic [ADDR_W-1:0] addr);
        int gap;
        func             <= fn;
        amount_requested <= amt;
        page_addr        <= addr;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [ADDR_W-1:0] page_at(int blk, int pg, int ofs);
        return ADDR_W'((blk << 18) | (pg << 12) | ofs);
    endfunction

    // Stimulus and verdict
    initial
    begin
        int r;
        in_valid         = 1'b0;
        func             = FN_MAP;
        amount_requested = '0;
        page_addr        = '0;
        rst_n            = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty allocator, limits, every function
        send_word(FN_ALLOC, 7'd5, '0);
        send_word(FN_FREE, '0, page_at(0, 0, 0));
        send_word(FN_MAP, 7'd0, '0);
        send_word(FN_ALLOC, 7'd0, '0);
        send_word(FN_MAP, 7'd1, '0);
        send_word(FN_ALLOC, 7'd65, '0);
        send_word(FN_ALLOC, 7'd127, '0);
        send_word(FN_ALLOC, 7'd64, '0);
        send_word(FN_ALLOC, 7'd1, '0);
        send_word(FN_FREE, '0, page_at(0, 63, 12'hFFF));
        send_word(FN_FREE, '0, page_at(0, 63, 0));
        send_word(FN_ALLOC, 7'd3, '0);
        send_word(FN_MAP, 7'd2, '0);
        send_word(FN_ALLOC, 7'd64, '0);
        send_word(FN_ALLOC, 7'd64, '0);
        send_word(FN_FREE, '0, page_at(15, 63, 12'hFFF));
        send_word(FN_FREE, '0, page_at(2, 0, 12'h5A5));
        send_word(FN_UNKNOWN, 7'h7F, 22'h3FFFFF);
        send_word(FN_MAP, 7'd127, '0);
        send_word(FN_MAP, 7'd3, '0);
        send_word(FN_ALLOC, 7'd40, '0);
        send_word(FN_FREE, '0, page_at(15, 0, 0));

        // Random mix weighted toward allocate and free requests
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_word(FN_MAP, AMT_W'($urandom_range(0, 2)), ADDR_W'($urandom));
            else if (r < 50)
                send_word(FN_ALLOC,
                          ($urandom_range(0, 9) == 0) ? AMT_W'($urandom_range(0, 127))
                                                      : AMT_W'($urandom_range(1, 12)),
                          ADDR_W'($urandom));
            else if (r < 95)
                send_word(FN_FREE, AMT_W'($urandom),
                          page_at($urandom_range(0, 15), $urandom_range(0, 63),
                                  $urandom_range(0, 4095)));
            else
                send_word(FN_UNKNOWN, AMT_W'($urandom), ADDR_W'($urandom));
        end
        in_valid <= 1'b0;

        // Drain, then let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
